[rtl/egas_pkg.sv]
// ----------------------------------------------------------------------------
// egas_pkg
// Shared types and constants for the electron gas basis / two-body block.
// ----------------------------------------------------------------------------
package egas_pkg;

  localparam int CMD_W = 2;
  localparam int IDX_W = 9;
  localparam int CNT_W = 10;
  localparam int E_W   = 38;
  localparam int TB_W  = 50;
  localparam int CFG_W = 32;
  localparam int NX_W  = 5;  // signed lattice coordinate
  localparam int SH_W  = 11; // shell value
  localparam int ENT_W = SH_W + 2 * NX_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_BUILD = 2'd0,
    CMD_ONE   = 2'd1,
    CMD_TWO   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SHELL = 2'd0,
    REG_INVV  = 2'd1,
    REG_ESCL  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [SH_W-1:0]        e;
    logic signed [NX_W-1:0] nx;
    logic signed [NX_W-1:0] ny;
    logic                   spin;
  } entry_t;

  // divider request / reply
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [11:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quo;
  } div_rsp_t;

endpackage

[rtl/egas_ram.sv]
// ----------------------------------------------------------------------------
// egas_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module egas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/egas_div.sv]
// ----------------------------------------------------------------------------
// egas_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module egas_div (
  input  logic               clk,
  input  logic               rst_n,
  input  egas_pkg::div_req_t req,
  output egas_pkg::div_rsp_t rsp
);

  logic [47:0] quo_r, quo_nxt;
  logic [12:0] rem_r, rem_nxt;
  logic [11:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [12:0] sh;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r[11:0], quo_r[47]};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        quo_nxt = {quo_r[46:0], 1'b1};
      end else begin
        rem_nxt = sh;
        quo_nxt = {quo_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd47) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

[rtl/electron_gas_basis_and_two_body_element.sv]
// ----------------------------------------------------------------------------
// electron_gas_basis_and_two_body_element
// Plane-wave state table build, one-body energy and Coulomb two-body element.
// ----------------------------------------------------------------------------
// channel | dir | ports
// in      | in  | in_valid, in_stall, in_command, in_index_p/q/r/s
// out     | out | out_valid, out_stall, out_state_count, out_one_body_energy,
//         |     | out_two_body_value, out_index_error
// cfg     | in  | cfg_we, cfg_index, cfg_data
// One transaction at a time; in_stall is high while busy or while a result
// is held. Build: walks each lattice point of the (2m+1)^2 square per
// shell, two writes per hit. One-body: one table read.
// Two-body: 4 table reads then up to two divides.
// Reset is synchronous; the table is undefined until a build.
// ----------------------------------------------------------------------------
module electron_gas_basis_and_two_body_element #(
  parameter int MAX_STATES = 512,
  parameter int MAX_SHELLS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [8:0]  in_index_p,
  input  logic [8:0]  in_index_q,
  input  logic [8:0]  in_index_r,
  input  logic [8:0]  in_index_s,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_state_count,
  output logic [37:0] out_one_body_energy,
  output logic signed [49:0] out_two_body_value,
  output logic        out_index_error,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW  = $clog2(MAX_STATES);
  localparam int SZW = $clog2(MAX_STATES + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_BUILD = 10'b0000000010,
    S_WR1   = 10'b0000000100,
    S_RD    = 10'b0000001000,
    S_RDW   = 10'b0000010000,
    S_EVAL  = 10'b0000100000,
    S_DIV1  = 10'b0001000000,
    S_DIV2  = 10'b0010000000,
    S_MUL   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0]  shell_cfg_r;
  logic [31:0] inv_vol_r, escale_r;
  logic [SZW-1:0] size_r, size_nxt;

  logic [1:0] cmd_r, cmd_nxt;
  logic [8:0] idx_r [4];
  logic [8:0] idx_nxt [4];
  logic [1:0] rd_cnt_r, rd_cnt_nxt;
  egas_pkg::entry_t ent_r [4];

  logic [10:0] sh_r, sh_nxt;
  logic [10:0] shells_lim;
  logic signed [5:0] m_r, m_nxt, x_r, x_nxt, y_r, y_nxt;

  logic [9:0]  res_cnt_r;
  logic [37:0] res_one_r, res_one_nxt;
  logic [49:0] res_two_r, res_two_nxt;
  logic        res_err_r, res_err_nxt;
  logic [47:0] t1_r, t1_nxt;
  logic        use2_r, use2_nxt;
  logic [11:0] d2_r, d2_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  egas_pkg::entry_t     ram_wd;
  logic [egas_pkg::ENT_W-1:0] ram_rd;

  egas_pkg::div_req_t dreq;
  egas_pkg::div_rsp_t drsp;

  egas_ram #(.WIDTH(egas_pkg::ENT_W), .DEPTH(MAX_STATES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  egas_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shell_cfg_r <= 7'd4;
      inv_vol_r   <= '0;
      escale_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        egas_pkg::REG_SHELL: shell_cfg_r <= cfg_data[6:0];
        egas_pkg::REG_INVV:  inv_vol_r   <= cfg_data;
        egas_pkg::REG_ESCL:  escale_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign shells_lim = ({4'd0, shell_cfg_r} > 11'(MAX_SHELLS)) ? 11'(MAX_SHELLS)
                                                            : {4'd0, shell_cfg_r};

  // evaluation helpers (registered entries)
  logic signed [6:0] sx_l, sx_r2, sy_l, sy_r2, dxr, dyr, dxs, dys;
  logic [11:0] dr2, ds2;
  logic sum_ok, sp1, sp2, hit;
  logic [12:0] sq;
  logic [47:0] num48;
  logic [48:0] diff;
  logic [42:0] eprod;

  always_comb begin
    sx_l  = 7'(ent_r[0].nx) + 7'(ent_r[1].nx);
    sy_l  = 7'(ent_r[0].ny) + 7'(ent_r[1].ny);
    sx_r2 = 7'(ent_r[2].nx) + 7'(ent_r[3].nx);
    sy_r2 = 7'(ent_r[2].ny) + 7'(ent_r[3].ny);
    sum_ok = (sx_l == sx_r2) && (sy_l == sy_r2);
    dxr = 7'(ent_r[2].nx) - 7'(ent_r[0].nx);
    dyr = 7'(ent_r[2].ny) - 7'(ent_r[0].ny);
    dxs = 7'(ent_r[3].nx) - 7'(ent_r[0].nx);
    dys = 7'(ent_r[3].ny) - 7'(ent_r[0].ny);
    dr2 = 12'(dxr * dxr) + 12'(dyr * dyr);
    ds2 = 12'(dxs * dxs) + 12'(dys * dys);
    sp1 = (ent_r[0].spin == ent_r[2].spin) && (ent_r[1].spin == ent_r[3].spin)
          && (dr2 != 12'd0);
    sp2 = (ent_r[0].spin == ent_r[3].spin) && (ent_r[1].spin == ent_r[2].spin)
          && (ds2 != 12'd0);
    sq  = 13'(x_r * x_r) + 13'(y_r * y_r);
    hit = (sq == {2'd0, sh_r});
    diff  = {1'b0, t1_r} - {1'b0, drsp.quo};
    eprod = ent_r[0].e * escale_r;
  end

  function automatic logic [47:0] div_num(input logic [31:0] iv, input logic [11:0] d);
    div_num = {iv, 16'd0} + {37'd0, d[11:1]};
  endfunction

  always_comb begin
    state_nxt   = state_r;
    size_nxt    = size_r;
    cmd_nxt     = cmd_r;
    idx_nxt     = idx_r;
    rd_cnt_nxt  = rd_cnt_r;
    sh_nxt      = sh_r;
    m_nxt       = m_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    res_one_nxt = res_one_r;
    res_two_nxt = res_two_r;
    res_err_nxt = res_err_r;
    t1_nxt      = t1_r;
    use2_nxt    = use2_r;
    d2_nxt      = d2_r;
    ram_we      = 1'b0;
    ram_addr    = AW'(idx_r[rd_cnt_r]);
    ram_wd      = '{e: sh_r, nx: x_r[4:0], ny: y_r[4:0], spin: 1'b0};
    dreq        = '{start: 1'b0, num: '0, den: '0};
    num48       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_command;
          idx_nxt[0]  = in_index_p;
          idx_nxt[1]  = in_index_q;
          idx_nxt[2]  = in_index_r;
          idx_nxt[3]  = in_index_s;
          rd_cnt_nxt  = 2'd0;
          res_one_nxt = '0;
          res_two_nxt = '0;
          res_err_nxt = 1'b0;
          case (in_command)
            egas_pkg::CMD_BUILD: begin
              size_nxt  = '0;
              sh_nxt    = '0;
              m_nxt     = '0;
              x_nxt     = '0;
              y_nxt     = '0;
              state_nxt = (shells_lim == 11'd0) ? S_OUT : S_BUILD;
            end
            egas_pkg::CMD_ONE: begin
              if ({1'b0, in_index_p} >= 10'(size_r) || {1'b0, in_index_q} >= 10'(size_r)) begin
                res_err_nxt = 1'b1;
                state_nxt   = S_OUT;
              end else if (in_index_p != in_index_q) begin
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_RD;
              end
            end
            egas_pkg::CMD_TWO: begin
              if ({1'b0, in_index_p} >= 10'(size_r) || {1'b0, in_index_q} >= 10'(size_r) ||
                  {1'b0, in_index_r} >= 10'(size_r) || {1'b0, in_index_s} >= 10'(size_r)) begin
                res_err_nxt = 1'b1;
                state_nxt   = S_OUT;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_BUILD: begin
        // walk x,y over [-m,m]; m grows while (m+1)^2 <= shell
        if (x_r == -m_r && y_r == -m_r &&
            13'((m_r + 6'sd1) * (m_r + 6'sd1)) <= {2'd0, sh_r}) begin
          m_nxt = m_r + 6'sd1;
          x_nxt = -(m_r + 6'sd1);
          y_nxt = -(m_r + 6'sd1);
        end else if (hit && size_r < SZW'(MAX_STATES)) begin
          ram_we    = 1'b1;
          ram_addr  = AW'(size_r);
          size_nxt  = size_r + SZW'(1);
          state_nxt = S_WR1;
        end else if (hit) begin
          state_nxt = S_OUT;
        end else begin
          if (y_r != m_r) begin
            y_nxt = y_r + 6'sd1;
          end else if (x_r != m_r) begin
            x_nxt = x_r + 6'sd1;
            y_nxt = -m_r;
          end else if (sh_r + 11'd1 >= shells_lim) begin
            state_nxt = S_OUT;
          end else begin
            sh_nxt = sh_r + 11'd1;
            x_nxt  = -m_r;
            y_nxt  = -m_r;
          end
        end
      end
      S_WR1: begin
        if (size_r >= SZW'(MAX_STATES)) begin
          state_nxt = S_OUT;
        end else begin
          ram_we      = 1'b1;
          ram_addr    = AW'(size_r);
          ram_wd.spin = 1'b1;
          size_nxt    = size_r + SZW'(1);
          state_nxt   = S_BUILD;
          if (y_r != m_r) begin
            y_nxt = y_r + 6'sd1;
          end else if (x_r != m_r) begin
            x_nxt = x_r + 6'sd1;
            y_nxt = -m_r;
          end else if (sh_r + 11'd1 >= shells_lim) begin
            state_nxt = S_OUT;
          end else begin
            sh_nxt = sh_r + 11'd1;
            x_nxt  = -m_r;
            y_nxt  = -m_r;
          end
        end
      end
      S_RD: begin
        ram_addr  = AW'(idx_r[rd_cnt_r]);
        state_nxt = S_RDW;
      end
      S_RDW: begin
        if (cmd_r == egas_pkg::CMD_ONE) begin
          state_nxt = S_MUL;
        end else if (rd_cnt_r == 2'd3) begin
          state_nxt = S_EVAL;
        end else begin
          rd_cnt_nxt = rd_cnt_r + 2'd1;
          state_nxt  = S_RD;
        end
      end
      S_MUL: begin
        res_one_nxt = (eprod[42:38] != '0) ? '1 : eprod[37:0];
        state_nxt   = S_OUT;
      end
      S_EVAL: begin
        if (!sum_ok) begin
          state_nxt = S_OUT;
        end else begin
          use2_nxt = sp2;
          d2_nxt   = ds2;
          t1_nxt   = '0;
          if (sp1) begin
            num48 = div_num(inv_vol_r, dr2);
            dreq  = '{start: 1'b1, num: num48, den: dr2};
            state_nxt = S_DIV1;
          end else if (sp2) begin
            num48 = div_num(inv_vol_r, ds2);
            dreq  = '{start: 1'b1, num: num48, den: ds2};
            state_nxt = S_DIV2;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_DIV1: begin
        if (drsp.done) begin
          t1_nxt = drsp.quo;
          if (use2_r) begin
            num48 = div_num(inv_vol_r, d2_r);
            dreq  = '{start: 1'b1, num: num48, den: d2_r};
            state_nxt = S_DIV2;
          end else begin
            res_two_nxt = {2'b00, drsp.quo};
            state_nxt   = S_OUT;
          end
        end
      end
      S_DIV2: begin
        if (drsp.done) begin
          res_two_nxt = {diff[48], diff};
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      size_r  <= '0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
    end
    cmd_r     <= cmd_nxt;
    idx_r     <= idx_nxt;
    rd_cnt_r  <= rd_cnt_nxt;
    sh_r      <= sh_nxt;
    m_r       <= m_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    res_one_r <= res_one_nxt;
    res_two_r <= res_two_nxt;
    res_err_r <= res_err_nxt;
    t1_r      <= t1_nxt;
    use2_r    <= use2_nxt;
    d2_r      <= d2_nxt;
    if (state_r == S_RDW) begin
      ent_r[rd_cnt_r] <= ram_rd;
    end
  end

  assign res_cnt_r = 10'(size_r);

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = (state_r == S_OUT);
  assign out_state_count     = res_cnt_r;
  assign out_one_body_energy = res_one_r;
  assign out_two_body_value  = res_two_r;
  assign out_index_error     = res_err_r;

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_error |-> out_one_body_energy == '0 && out_two_body_value == '0)
    else $error("error result carries data");
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("accepting while result pending");
  a_size_max: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= SZW'(MAX_STATES))
    else $error("table overflow");
`endif

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for electron_gas_basis_and_two_body_element: builds state tables
// at several shell counts, checks one-body energies and two-body elements
// against an in-bench predictor, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTATES = 512;
  localparam int NSHELLS = 64;

  typedef struct {
    logic [9:0]  cnt;
    logic [37:0] energy;
    logic [49:0] elem;
    logic        err;
  } gas_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = '0;
  logic [8:0] in_index_p = '0, in_index_q = '0, in_index_r = '0, in_index_s = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [9:0] out_state_count;
  logic [37:0] out_one_body_energy;
  logic signed [49:0] out_two_body_value;
  logic out_index_error;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  electron_gas_basis_and_two_body_element DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  int          tab_e[NSTATES];
  int          tab_x[NSTATES];
  int          tab_y[NSTATES];
  bit          tab_spin[NSTATES];
  int          tab_size = 0;
  int          shells = 4;
  logic [31:0] inv_vol = '0;
  logic [31:0] e_scale = '0;

  gas_result_t expected_q[$];
  int errors = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  function automatic void build_states();
    int n;
    int m;
    n = shells > NSHELLS ? NSHELLS : shells;
    tab_size = 0;
    for (int sh = 0; sh < n; sh++) begin
      m = 0;
      while ((m + 1) * (m + 1) <= sh) m++;
      for (int x = -m; x <= m; x++)
        for (int y = -m; y <= m; y++)
          if (x * x + y * y == sh)
            for (int sp = 0; sp < 2; sp++) begin
              if (tab_size >= NSTATES) return;
              tab_e[tab_size] = sh;
              tab_x[tab_size] = x;
              tab_y[tab_size] = y;
              tab_spin[tab_size] = sp[0];
              tab_size++;
            end
    end
  endfunction

  function automatic logic [63:0] coulomb_term(int a, int b);
    longint unsigned d;
    longint unsigned num;
    d = (tab_x[a] - tab_x[b]) * (tab_x[a] - tab_x[b]) +
        (tab_y[a] - tab_y[b]) * (tab_y[a] - tab_y[b]);
    num = {16'd0, inv_vol, 16'd0};
    if (d == 0) return 64'd0;
    return (num + d / 2) / d;
  endfunction

  function automatic gas_result_t predict_gas(egas_pkg::cmd_t c, int p, int q, int r, int s);
    gas_result_t res;
    logic [63:0] v;
    logic [63:0] t1;
    logic [63:0] t2;
    res = '{default: '0};
    if (c == egas_pkg::CMD_BUILD) begin
      build_states();
    end else if (c == egas_pkg::CMD_ONE) begin
      if (p >= tab_size || q >= tab_size) res.err = 1'b1;
      else if (p == q) begin
        v = 64'(tab_e[p]) * 64'(e_scale);
        res.energy = v > 64'h3F_FFFF_FFFF ? 38'h3F_FFFF_FFFF : v[37:0];
      end
    end else if (c == egas_pkg::CMD_TWO) begin
      if (p >= tab_size || q >= tab_size || r >= tab_size || s >= tab_size)
        res.err = 1'b1;
      else if (tab_x[p] + tab_x[q] == tab_x[r] + tab_x[s] &&
               tab_y[p] + tab_y[q] == tab_y[r] + tab_y[s]) begin
        t1 = 0;
        t2 = 0;
        if (tab_spin[p] == tab_spin[r] && tab_spin[q] == tab_spin[s]) t1 = coulomb_term(r, p);
        if (tab_spin[p] == tab_spin[s] && tab_spin[q] == tab_spin[r]) t2 = coulomb_term(s, p);
        v = t1 - t2;
        res.elem = v[49:0];
      end
    end
    res.cnt = tab_size[9:0];
    return res;
  endfunction

  task automatic write_reg(egas_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      egas_pkg::REG_SHELL: shells = val[6:0];
      egas_pkg::REG_INVV:  inv_vol = val;
      egas_pkg::REG_ESCL:  e_scale = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_gas(egas_pkg::cmd_t c, int p, int q, int r, int s);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_command <= c;
    in_index_p <= p[8:0];
    in_index_q <= q[8:0];
    in_index_r <= r[8:0];
    in_index_s <= s[8:0];
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_gas(c, p, q, r, s));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // reply checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: count %0d", out_state_count);
      end else begin
        gas_result_t x;
        x = expected_q.pop_front();
        if (x.cnt !== out_state_count || x.energy !== out_one_body_energy ||
            x.elem !== out_two_body_value || x.err !== out_index_error) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp cnt %0d e %h v %h err %b, got cnt %0d e %h v %h err %b",
                     x.cnt, x.energy, x.elem, x.err, out_state_count,
                     out_one_body_energy, out_two_body_value, out_index_error);
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // random two-body that conserves momentum most of the time
  task automatic random_two();
    int p, q, r, s, k;
    p = $urandom_range(tab_size - 1);
    q = $urandom_range(tab_size - 1);
    r = $urandom_range(tab_size - 1);
    s = r;
    k = $urandom_range(99);
    if (k < 70) begin
      for (int t = 0; t < 40; t++) begin
        r = $urandom_range(tab_size - 1);
        for (s = 0; s < tab_size; s++)
          if (tab_x[p] + tab_x[q] == tab_x[r] + tab_x[s] &&
              tab_y[p] + tab_y[q] == tab_y[r] + tab_y[s] && $urandom_range(3) == 0) break;
        if (s < tab_size) break;
      end
      if (s >= tab_size) begin r = p; s = q; end
      if ($urandom_range(1)) s = s ^ 1;
    end else if (k < 80) begin
      s = $urandom_range(511);
    end else begin
      s = $urandom_range(tab_size - 1);
    end
    send_gas(egas_pkg::CMD_TWO, p, q, r, s);
  endtask

  task automatic test_directed();
    write_reg(egas_pkg::REG_SHELL, 32'd1);
    write_reg(egas_pkg::REG_INVV, 32'hFFFF_FFFF);
    write_reg(egas_pkg::REG_ESCL, 32'hFFFF_FFFF);
    send_gas(egas_pkg::CMD_ONE, 0, 0, 0, 0);
    send_gas(egas_pkg::CMD_NONE, 511, 511, 511, 511);
    send_gas(egas_pkg::CMD_BUILD, 0, 0, 0, 0);
    send_gas(egas_pkg::CMD_ONE, 1, 1, 0, 0);
    send_gas(egas_pkg::CMD_ONE, 2, 0, 0, 0);
    drain();
    write_reg(egas_pkg::REG_SHELL, 32'd0);
    send_gas(egas_pkg::CMD_BUILD, 0, 0, 0, 0);
    send_gas(egas_pkg::CMD_TWO, 0, 0, 0, 0);
    drain();
    write_reg(egas_pkg::REG_SHELL, 32'h7F);
    send_gas(egas_pkg::CMD_BUILD, 511, 511, 511, 511);
    send_gas(egas_pkg::CMD_ONE, 511, 511, 0, 0);
    send_gas(egas_pkg::CMD_ONE, 300, 301, 0, 0);
    send_gas(egas_pkg::CMD_TWO, 0, 1, 0, 1);
    send_gas(egas_pkg::CMD_TWO, 2, 3, 3, 2);
    send_gas(egas_pkg::CMD_TWO, 2, 4, 4, 2);
    send_gas(egas_pkg::CMD_TWO, 511, 0, 0, 0);
    send_gas(egas_pkg::CMD_TWO, 0, 0, 0, 511);
    send_gas(egas_pkg::CMD_NONE, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_random(int n, int sh, logic [31:0] iv, logic [31:0] es);
    int k;
    write_reg(egas_pkg::REG_SHELL, 32'(sh));
    write_reg(egas_pkg::REG_INVV, iv);
    write_reg(egas_pkg::REG_ESCL, es);
    send_gas(egas_pkg::CMD_BUILD, $urandom_range(511), $urandom_range(511),
             $urandom_range(511), $urandom_range(511));
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (tab_size == 0 || k < 3)
        send_gas(egas_pkg::cmd_t'($urandom_range(3) == 0 ? egas_pkg::CMD_NONE
                                                         : egas_pkg::CMD_BUILD),
                 $urandom_range(511), $urandom_range(511), 0, 0);
      else if (k < 35)
        send_gas(egas_pkg::CMD_ONE, $urandom_range(tab_size - 1),
                 $urandom_range(3) == 0 ? $urandom_range(511) : $urandom_range(tab_size - 1),
                 $urandom_range(511), $urandom_range(511));
      else random_two();
      if (i == n / 2) drain();
    end
    drain();
  endtask

  task automatic test_pressure_phases();
    send_gap_pct = 16;
    recv_stall_pct = 75;
    test_random(450, 20, $urandom, $urandom);
    send_gap_pct = 75;
    recv_stall_pct = 16;
    test_random(450, 64, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_random(500, 6, $urandom, $urandom);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pressure_phases();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #10000000;
    $display("FAIL");
    $finish;
  end
endmodule

[sim.f]
rtl/egas_pkg.sv
rtl/egas_ram.sv
rtl/egas_div.sv
rtl/electron_gas_basis_and_two_body_element.sv
test/tb_top.sv
